>>> rtl/spq_pkg.sv
// Package for the stable priority queue: entry, command, status and cell control types.
// It depends on nothing. The cell, the top level and the checker import it.
package spq_pkg;

   // Field widths are fixed by the beat format.
   localparam int PRIO_W   = 8;
   localparam int HANDLE_W = 16;
   localparam int OCC_W    = 6;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // One held entry.
   typedef struct packed {
      logic [PRIO_W-1:0]   prio;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   // What every cell does in a cycle.
   typedef enum logic [1:0] {
      CELL_HOLD    = 2'd0,
      CELL_INSERT  = 2'd1,
      CELL_DEQUEUE = 2'd2
   } cell_op_type;

   // Control that is broadcast to the whole row of cells.
   typedef struct packed {
      cell_op_type op;
      entry_type   fresh;
   } cell_ctrl_type;

endpackage

>>> rtl/spq_cell.sv
// One storage cell of the sorted row: holds a single entry and moves it to a neighbour.
// It depends on spq_pkg for the entry and control types.
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,     // this position lies below the count
   input  logic          left_ge,      // the cell towards the head keeps its entry
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          keep_ge       // this cell keeps its entry on an insert
);

   entry_type entry_ff;
   entry_type entry_in;

   // A held entry of greater or equal priority stays ahead of the new one.
   assign keep_ge = occupied && (entry_ff.prio >= ctrl.fresh.prio);

   // Next entry: hold, take the new entry at the insertion point,
   // take the left neighbour behind it, or take the right neighbour on a dequeue.
   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            if (keep_ge) begin
               entry_in = entry_ff;
            end else if (left_ge) begin
               entry_in = ctrl.fresh;
            end else begin
               entry_in = left_entry;
            end
         end
         CELL_DEQUEUE: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> rtl/stable_priority_queue.sv
// Top level of the stable priority queue: count, command decode, row of cells, result beat.
// It depends on spq_pkg and instantiates spq_cell once per position.
//
//   channel | direction | tdata (low bit up)                      | tuser
//   req     | in        | priority_req[7:0], payload[23:8]        | command
//   rsp     | out       | out_payload[15:0], out_priority[23:16], | status[1:0]
//           |           | occupancy[29:24], is_empty[30],         |
//           |           | is_full[31]                             |
//
// Every request beat is worked in the cycle that accepts it; its result beat is shown from
// the next cycle on, so one item per cycle is sustained while results are taken.
// The row of cells shifts all entries at once, which lets a request be worked as it is accepted.
// Reset empties the queue; no clearing pass is needed.
// A stalled result beat holds; a new request is taken only when the result register is free
// or is being taken in the same cycle.
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // priority_req[7:0], payload[23:8]
   input  logic        req_tuser,    // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // out_payload, out_priority, occupancy, is_empty, is_full
   output logic [1:0]  rsp_tuser     // status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   status_type       status_ff;
   status_type       status_in;
   entry_type        out_ff;
   entry_type        out_in;
   logic [CNT_W-1:0] occ_ff;

   logic             accept;
   logic             full_now;
   logic             empty_now;
   cell_ctrl_type    ctrl;
   entry_type        cell_entry [CAPACITY];
   logic             cell_ge    [CAPACITY];

   assign accept    = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign full_now  = (count_ff == CNT_W'(CAPACITY));
   assign empty_now = (count_ff == '0);

   // Decode the command into a row operation, the new count and the result.
   always_comb begin
      ctrl.op           = CELL_HOLD;
      ctrl.fresh.prio   = req_tdata[7:0];
      ctrl.fresh.handle = req_tdata[23:8];
      count_in          = count_ff;
      status_in         = ST_DONE;
      out_in            = '0;
      if (accept) begin
         unique case (command_type'(req_tuser))
            CMD_ENQUEUE: begin
               if (full_now) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.op  = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_DEQUEUE: begin
               if (empty_now) begin
                  status_in = ST_EMPTY;
               end else begin
                  ctrl.op  = CELL_DEQUEUE;
                  out_in   = cell_entry[0];
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end
   end

   // The sorted row; the head sits in cell zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      left_ge;
      entry_type left_entry;
      entry_type right_entry;
      if (i == 0) begin : g_head
         assign left_ge    = 1'b1;
         assign left_entry = '0;
      end else begin : g_body
         assign left_ge    = cell_ge[i-1];
         assign left_entry = cell_entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > CNT_W'(i)),
         .left_ge     (left_ge),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .keep_ge     (cell_ge[i])
      );
   end

   // Result beat valid: set by an accepted request, cleared when taken.
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded with every accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         out_ff    <= out_in;
         occ_ff    <= count_in;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tuser       = status_ff;
   assign rsp_tdata[15:0]  = out_ff.handle;
   assign rsp_tdata[23:16] = out_ff.prio;
   assign rsp_tdata[29:24] = OCC_W'(occ_ff);
   assign rsp_tdata[30]    = (occ_ff == '0);
   assign rsp_tdata[31]    = (occ_ff == CNT_W'(CAPACITY));

endmodule

>>> rtl/spq_checker.sv
// Port checker for the stable priority queue, bound to the top level.
// It depends on spq_pkg for the status codes.
module spq_checker
   import spq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // No result beat straight after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat shown after reset");

   // A rejected or empty item carries no entry.
   a_zero_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_FULL || rsp_tuser == ST_EMPTY))
         |-> (rsp_tdata[23:0] == 24'd0))
      else $error("failed item carries an entry");

   // A dequeue on empty leaves the queue empty.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_EMPTY) |-> rsp_tdata[30])
      else $error("empty status without empty flag");

   // Empty and full never hold together.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[30] && rsp_tdata[31]))
      else $error("empty and full both set");

   // A stalled result beat holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result beat changed");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/stable_priority_queue_check.sv
// Checker for the stable priority queue: watches both streams, predicts every result beat
// and compares it field by field. It depends on spq_pkg and is instantiated by the test top.
module stable_priority_queue_check
   import spq_pkg::*;
#(
   parameter int CAPACITY = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,    // priority_req[7:0], payload[23:8]
   input  logic        req_tuser,    // command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // out_payload, out_priority, occupancy, is_empty, is_full
   input  logic [1:0]  rsp_tuser,    // status
   output int          error_count,
   output int          outstanding,
   output int          results_seen,
   output int          full_rejects,
   output int          empty_dequeues,
   output int          peak_occupancy
);

   // One predicted result beat.
   typedef struct {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
      logic [PRIO_W-1:0]   prio;
      logic [OCC_W-1:0]    occupancy;
      logic                is_empty;
      logic                is_full;
   } outcome_type;

   // Shadow of the held entries, head first, and the results still to arrive.
   entry_type   shadow_entries[$];
   outcome_type awaited_outcomes[$];

   initial begin
      error_count    = 0;
      outstanding    = 0;
      results_seen   = 0;
      full_rejects   = 0;
      empty_dequeues = 0;
      peak_occupancy = 0;
   end

   task automatic report(input string msg);
      $display("%0t: queue check: %s", $time, msg);
      error_count++;
   endtask

   // Applies one command to the shadow queue and returns the result it should produce.
   function automatic outcome_type apply_command(input command_type cmd,
                                                 input logic [PRIO_W-1:0] prio,
                                                 input logic [HANDLE_W-1:0] handle);
      outcome_type res;
      entry_type   fresh;
      entry_type   head;
      int          slot;
      res.status = ST_DONE;
      res.handle = '0;
      res.prio   = '0;
      if (cmd == CMD_ENQUEUE) begin
         if (shadow_entries.size() >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            // A new entry goes behind every entry of greater or equal priority.
            slot = 0;
            while (slot < shadow_entries.size() && shadow_entries[slot].prio >= prio)
               slot++;
            fresh.prio   = prio;
            fresh.handle = handle;
            shadow_entries.insert(slot, fresh);
         end
      end else begin
         if (shadow_entries.size() == 0) begin
            res.status = ST_EMPTY;
         end else begin
            head       = shadow_entries.pop_front();
            res.handle = head.handle;
            res.prio   = head.prio;
         end
      end
      res.occupancy = OCC_W'(shadow_entries.size());
      res.is_empty  = (shadow_entries.size() == 0);
      res.is_full   = (shadow_entries.size() >= CAPACITY);
      return res;
   endfunction

   // Compare a result beat against the oldest prediction, then predict for a request beat.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         shadow_entries.delete();
         awaited_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (awaited_outcomes.size() == 0) begin
               report($sformatf("result beat with nothing expected, tdata %h tuser %h",
                                rsp_tdata, rsp_tuser));
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_tuser !== want.status)
                  report($sformatf("status got %0d expected %0d", rsp_tuser, want.status));
               if (rsp_tdata[15:0] !== want.handle)
                  report($sformatf("out_payload got %h expected %h",
                                   rsp_tdata[15:0], want.handle));
               if (rsp_tdata[23:16] !== want.prio)
                  report($sformatf("out_priority got %0d expected %0d",
                                   rsp_tdata[23:16], want.prio));
               if (rsp_tdata[29:24] !== want.occupancy)
                  report($sformatf("occupancy got %0d expected %0d",
                                   rsp_tdata[29:24], want.occupancy));
               if (rsp_tdata[30] !== want.is_empty)
                  report($sformatf("is_empty got %b expected %b", rsp_tdata[30], want.is_empty));
               if (rsp_tdata[31] !== want.is_full)
                  report($sformatf("is_full got %b expected %b", rsp_tdata[31], want.is_full));
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_command(command_type'(req_tuser), req_tdata[7:0], req_tdata[23:8]);
            if (want.status == ST_FULL)
               full_rejects++;
            if (want.status == ST_EMPTY)
               empty_dequeues++;
            if (shadow_entries.size() > peak_occupancy)
               peak_occupancy = shadow_entries.size();
            awaited_outcomes.push_back(want);
         end
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

>>> tb/stable_priority_queue_test.sv
// Test top for the stable priority queue: clock, reset, request stimulus and result stalls.
// It depends on spq_pkg, the block and stable_priority_queue_check, which checks every result beat.
module stable_priority_queue_test
   import spq_pkg::*;
();

   localparam int CAPACITY     = 32;
   localparam int RANDOM_ITEMS = 550;

   // How a random phase leans between the two commands.
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   // How the result side stalls for a stretch.
   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // priority_req[7:0], payload[23:8]
   logic        req_tuser;    // command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // out_payload, out_priority, occupancy, is_empty, is_full
   logic [1:0]  rsp_tuser;    // status

   int error_count;
   int outstanding;
   int results_seen;
   int full_rejects;
   int empty_dequeues;
   int peak_occupancy;
   int items_sent;

   stable_priority_queue #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   stable_priority_queue_check #(
      .CAPACITY (CAPACITY)
   ) i_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .error_count    (error_count),
      .outstanding    (outstanding),
      .results_seen   (results_seen),
      .full_rejects   (full_rejects),
      .empty_dequeues (empty_dequeues),
      .peak_occupancy (peak_occupancy)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("stable_priority_queue_test: done, errors");
      $finish;
   end

   // The result side stalls in stretches, each with its own pattern.
   initial begin
      stall_type mode;
      int        span;
      int        tick;
      rsp_tready = 1'b0;
      tick = 0;
      forever begin
         mode = stall_type'($urandom_range(0, 3));
         span = $urandom_range(16, 80);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               STALL_NONE:     rsp_tready <= 1'b1;
               STALL_HALF:     rsp_tready <= 1'($urandom_range(0, 1));
               STALL_HEAVY:    rsp_tready <= ($urandom_range(0, 3) == 0);
               default:        rsp_tready <= (tick % 5 != 0);
            endcase
         end
      end
   end

   // Offers one request beat from a falling edge and returns at the falling edge after
   // it has been taken, with valid still high.
   task automatic send_beat(input command_type cmd, input logic [7:0] prio,
                            input logic [15:0] handle);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {handle, prio};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   // Drops valid for a number of cycles; a zero gap keeps the burst going.
   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 24'($urandom);
         req_tuser  <= 1'($urandom_range(0, 1));
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Holds the sender until every predicted result has arrived or its guard runs out.
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
   endtask

   // Reset, a short directed part, then random phases that fill and drain the queue.
   initial begin
      mix_type     mix;
      command_type cmd;
      logic [7:0]  prio;
      logic [7:0]  prio_base;
      int          prio_spread;
      int          phase_len;
      int          burst_left;
      bit          gaps_on;
      bit          paused_once;
      int          settle;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_ENQUEUE;
      items_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty dequeue, field extremes, ties at both ends and drain past empty.
      send_beat(CMD_DEQUEUE, 8'hFF, 16'hFFFF);
      send_beat(CMD_ENQUEUE, 8'h00, 16'h0000);
      send_beat(CMD_ENQUEUE, 8'hFF, 16'hFFFF);
      send_beat(CMD_ENQUEUE, 8'hFF, 16'h1234);
      send_beat(CMD_ENQUEUE, 8'h00, 16'hAAAA);
      send_beat(CMD_ENQUEUE, 8'h80, 16'h5555);
      send_beat(CMD_ENQUEUE, 8'h80, 16'h00FF);
      send_beat(CMD_ENQUEUE, 8'h7F, 16'hFF00);
      send_beat(CMD_ENQUEUE, 8'hFF, 16'h8001);
      repeat (9) send_beat(CMD_DEQUEUE, 8'h00, 16'h0000);
      wait_drained();

      // Random phases; most lean firmly one way so that full and empty are both reached.
      paused_once = 1'b0;
      while (items_sent < RANDOM_ITEMS) begin
         mix         = mix_type'($urandom_range(0, 2));
         phase_len   = $urandom_range(20, 70);
         gaps_on     = ($urandom_range(0, 2) != 0);
         prio_spread = ($urandom_range(0, 1) == 0) ? 3 : 255;
         prio_base   = (prio_spread == 3) ? 8'($urandom_range(0, 252)) : 8'h00;
         burst_left  = $urandom_range(1, 12);
         repeat (phase_len) begin
            if (items_sent >= RANDOM_ITEMS)
               break;
            case (mix)
               MIX_FILL:  cmd = ($urandom_range(0, 99) < 85) ? CMD_ENQUEUE : CMD_DEQUEUE;
               MIX_DRAIN: cmd = ($urandom_range(0, 99) < 85) ? CMD_DEQUEUE : CMD_ENQUEUE;
               default:   cmd = command_type'($urandom_range(0, 1));
            endcase
            case ($urandom_range(0, 15))
               0:       prio = 8'h00;
               1:       prio = 8'hFF;
               default: prio = prio_base + 8'($urandom_range(0, prio_spread));
            endcase
            send_beat(cmd, prio, 16'($urandom));
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               if (gaps_on)
                  hold_off($urandom_range(1, 8));
            end
         end
         if (!paused_once && items_sent > RANDOM_ITEMS / 2) begin
            wait_drained();
            paused_once = 1'b1;
         end
      end

      // Let everything arrive, then wait on for any stray beat.
      wait_drained();
      repeat (8) @(negedge clock);
      settle = outstanding;

      $display("Run covered %0d request beats and %0d result beats, peak occupancy %0d.",
               items_sent, results_seen, peak_occupancy);
      $display("Enqueues rejected when full: %0d; dequeues on an empty queue: %0d.",
               full_rejects, empty_dequeues);
      if (settle != 0)
         $display("%0d results never arrived.", settle);
      if (error_count == 0 && settle == 0) begin
         $display("stable_priority_queue_test: done, clean");
      end else begin
         $display("stable_priority_queue_test: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
rtl/spq_checker.sv
tb/stable_priority_queue_check.sv
tb/stable_priority_queue_test.sv
